>>> hw/rtl/ole_pkg.sv
// Shared types and constants of the ordered list engine.
package ole_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_BITS = 4;

  typedef enum logic [2:0] {
    REQ_INSERT_AT    = 3'd0,
    REQ_INSERT_FRONT = 3'd1,
    REQ_INSERT_BACK  = 3'd2,
    REQ_DELETE_AT    = 3'd3,
    REQ_DELETE_FRONT = 3'd4,
    REQ_DELETE_BACK  = 3'd5,
    REQ_SEARCH       = 3'd6,
    REQ_READ_AT      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_DELETE  = 3'd2,
    CELL_MARK_EQ = 3'd3,
    CELL_MARK_AT = 3'd4
  } cell_op_t;

  typedef struct packed {
    req_t                     req_type;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic [POS_W-1:0]         result_position;
    logic signed [DATA_W-1:0] result_value;
    logic [CNT_W-1:0]         entry_count;
  } out_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

>>> hw/rtl/ole_cell.sv
// One list cell: holds one entry, shifts with its neighbors and flags matches.
module ole_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned LW  = 7
) (
  input  logic                         clk,
  input  ole_pkg::cell_op_t            op,
  input  logic [IW-1:0]                tgt,
  input  logic [LW-1:0]                len,
  input  logic [ole_pkg::DATA_W-1:0]   key,
  input  logic [ole_pkg::DATA_W-1:0]   left_val,
  input  logic [ole_pkg::DATA_W-1:0]   right_val,
  output logic [ole_pkg::DATA_W-1:0]   val,
  output logic                         flag
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [LW-1:0] MY_CNT = LW'(IDX);

  logic [ole_pkg::DATA_W-1:0] val_r;
  logic                       flag_r;

  always_ff @(posedge clk) begin
    case (op)
      ole_pkg::CELL_INSERT: begin
        if (MY_IDX > tgt) begin
          val_r <= left_val;
        end else if (MY_IDX == tgt) begin
          val_r <= key;
        end
      end
      ole_pkg::CELL_DELETE: begin
        if (MY_IDX >= tgt) begin
          val_r <= right_val;
        end
      end
      ole_pkg::CELL_MARK_EQ: begin
        flag_r <= (val_r == key) && (MY_CNT < len);
      end
      ole_pkg::CELL_MARK_AT: begin
        flag_r <= (MY_IDX == tgt);
      end
      default: begin
      end
    endcase
  end

  assign val  = val_r;
  assign flag = flag_r;

endmodule

>>> hw/rtl/ole_scan.sv
// Group scan unit: walks the cell flags sixteen at a time and finds the first hit.
module ole_scan #(
  parameter int unsigned NG  = 4,
  parameter int unsigned NGW = 2
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  input  logic [NGW-1:0]                                         first_grp,
  input  logic [NGW-1:0]                                         last_grp,
  input  logic [NG*ole_pkg::GRP_SIZE-1:0]                        flags,
  input  logic [NG*ole_pkg::GRP_SIZE-1:0][ole_pkg::DATA_W-1:0]   vals,
  output ole_pkg::scan_stat_t                                    stat,
  output logic [NGW+ole_pkg::GRP_BITS-1:0]                       idx,
  output logic [ole_pkg::DATA_W-1:0]                             value
);

  localparam int unsigned G  = ole_pkg::GRP_SIZE;
  localparam int unsigned GB = ole_pkg::GRP_BITS;

  logic                            busy_r;
  logic [NGW-1:0]                  grp_r;
  logic [NGW-1:0]                  last_r;
  ole_pkg::scan_stat_t             stat_r;
  logic [NGW+GB-1:0]               idx_r;
  logic [ole_pkg::DATA_W-1:0]      value_r;

  logic [NGW+GB-1:0]               base;
  logic [G-1:0]                    grp_flags;
  logic [G-1:0][ole_pkg::DATA_W-1:0] grp_vals;
  logic                            hit;
  logic [GB-1:0]                   off;
  logic [ole_pkg::DATA_W-1:0]      sel_val;

  assign base      = {grp_r, {GB{1'b0}}};
  assign grp_flags = flags[base +: G];
  assign grp_vals  = vals[base +: G];
  assign hit       = |grp_flags;

  always_comb begin
    off     = '0;
    sel_val = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (grp_flags[i]) begin
        off = GB'(i);
      end
    end
    for (int i = 0; i < G; i++) begin
      sel_val = sel_val | (grp_vals[i] & {ole_pkg::DATA_W{grp_flags[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      stat_r <= '0;
    end else begin
      if (start) begin
        busy_r      <= 1'b1;
        grp_r       <= first_grp;
        last_r      <= last_grp;
        stat_r.done <= 1'b0;
      end else if (busy_r) begin
        if (hit) begin
          busy_r       <= 1'b0;
          stat_r.done  <= 1'b1;
          stat_r.found <= 1'b1;
          idx_r        <= {grp_r, off};
          value_r      <= sel_val;
        end else if (grp_r == last_r) begin
          busy_r       <= 1'b0;
          stat_r.done  <= 1'b1;
          stat_r.found <= 1'b0;
        end else begin
          grp_r       <= grp_r + NGW'(1);
          stat_r.done <= 1'b0;
        end
      end else begin
        stat_r.done <= 1'b0;
      end
    end
  end

  assign stat  = stat_r;
  assign idx   = idx_r;
  assign value = value_r;

endmodule

>>> hw/rtl/ordered_list_engine.sv
// Top level of the ordered list engine: request decode, cell row and result register.
//
// The list lives in a row of CAPACITY cells; an insert shifts every cell above the
// insert point one place up, and a delete shifts them one place down. An insert or
// any request that fails its range check goes from transfer straight to the result
// state. Read and delete first run the match scan, which picks out the entry before
// a delete shifts the row. A search scans the groups that hold entries: the scan
// unit looks at 16 cells per cycle and stops at the first match. One request is in
// work at a time; the next one is taken while the last result still waits in the
// output register.
module ordered_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ole_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ole_pkg::out_t out_data
);

  localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = (LW > ole_pkg::POS_W) ? LW : ole_pkg::POS_W;
  localparam int unsigned G   = ole_pkg::GRP_SIZE;
  localparam int unsigned GB  = ole_pkg::GRP_BITS;
  localparam int unsigned NG  = (CAPACITY + G - 1) / G;
  localparam int unsigned NGW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned NC  = NG * G;
  localparam int unsigned DW  = ole_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  ole_pkg::req_t       req_r, req_nxt;
  logic [DW-1:0]       key_r, key_nxt;
  logic [IW-1:0]       tgt_r, tgt_nxt;
  ole_pkg::out_t       res_r, res_nxt;
  logic                out_valid_r;
  ole_pkg::out_t       out_data_r;

  logic                in_acc;
  logic                out_load;
  logic [CW-1:0]       pos_c;
  logic [CW-1:0]       len_c;
  logic [CW-1:0]       ins_p;
  logic [CW-1:0]       sel_p;
  logic                req_is_del;

  ole_pkg::cell_op_t   cell_op;
  logic [IW-1:0]       cell_tgt;
  logic                scan_start;
  logic [NGW-1:0]      scan_first;
  logic [NGW-1:0]      scan_last;
  ole_pkg::scan_stat_t scan_stat;
  logic [NGW+GB-1:0]   scan_idx;
  logic [DW-1:0]       scan_val;

  logic [NC-1:0][DW-1:0] cell_vals;
  logic [NC-1:0]         cell_flags;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign pos_c    = CW'(in_data.position);
  assign len_c    = CW'(len_r);
  assign req_is_del = (req_r == ole_pkg::REQ_DELETE_AT) ||
                      (req_r == ole_pkg::REQ_DELETE_FRONT) ||
                      (req_r == ole_pkg::REQ_DELETE_BACK);

  always_comb begin
    unique case (in_data.req_type) inside
      ole_pkg::REQ_INSERT_FRONT: ins_p = '0;
      ole_pkg::REQ_INSERT_BACK:  ins_p = len_c;
      default:                   ins_p = (pos_c > len_c) ? len_c : pos_c;
    endcase
    unique case (in_data.req_type) inside
      ole_pkg::REQ_DELETE_FRONT: sel_p = '0;
      ole_pkg::REQ_DELETE_BACK:  sel_p = len_c - CW'(1);
      default:                   sel_p = pos_c;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    req_nxt    = req_r;
    key_nxt    = key_r;
    tgt_nxt    = tgt_r;
    res_nxt    = res_r;
    cell_op    = ole_pkg::CELL_HOLD;
    cell_tgt   = tgt_r;
    scan_start = 1'b0;
    scan_first = '0;
    scan_last  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_data.req_type;
          key_nxt   = in_data.item_value;
          res_nxt   = '0;
          state_nxt = S_DONE;
          unique case (in_data.req_type) inside
            ole_pkg::REQ_INSERT_AT, ole_pkg::REQ_INSERT_FRONT,
            ole_pkg::REQ_INSERT_BACK: begin
              if (len_r >= LW'(CAPACITY)) begin
                res_nxt.status = ole_pkg::ST_FULL;
              end else begin
                cell_op                 = ole_pkg::CELL_INSERT;
                cell_tgt                = IW'(ins_p);
                len_nxt                 = len_r + LW'(1);
                res_nxt.status          = ole_pkg::ST_OK;
                res_nxt.result_position = ole_pkg::POS_W'(ins_p);
              end
            end
            ole_pkg::REQ_DELETE_AT, ole_pkg::REQ_DELETE_FRONT,
            ole_pkg::REQ_DELETE_BACK, ole_pkg::REQ_READ_AT: begin
              if (sel_p >= len_c) begin
                res_nxt.status = ole_pkg::ST_RANGE;
              end else begin
                cell_op    = ole_pkg::CELL_MARK_AT;
                cell_tgt   = IW'(sel_p);
                tgt_nxt    = IW'(sel_p);
                scan_start = 1'b1;
                scan_first = NGW'(sel_p >> GB);
                scan_last  = NGW'(sel_p >> GB);
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              if (len_r == '0) begin
                res_nxt.status = ole_pkg::ST_NOT_FOUND;
              end else begin
                cell_op    = ole_pkg::CELL_MARK_EQ;
                scan_start = 1'b1;
                scan_first = '0;
                scan_last  = NGW'((len_c - CW'(1)) >> GB);
                state_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.found) begin
            res_nxt.status          = ole_pkg::ST_OK;
            res_nxt.result_position = ole_pkg::POS_W'(scan_idx);
            res_nxt.result_value    = (req_r == ole_pkg::REQ_SEARCH) ? key_r : scan_val;
            state_nxt               = req_is_del ? S_SHIFT : S_DONE;
          end else begin
            res_nxt.status = ole_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cell_op   = ole_pkg::CELL_DELETE;
        cell_tgt  = tgt_r;
        len_nxt   = len_r - LW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    key_r <= key_nxt;
    tgt_r <= tgt_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= {res_r.status, res_r.result_position, res_r.result_value,
                     ole_pkg::CNT_W'(len_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_in;
    logic [DW-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cell_vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cell_vals[i+1];
    end
    ole_cell #(
      .IDX (i),
      .IW  (IW),
      .LW  (LW)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .tgt       (cell_tgt),
      .len       (len_r),
      .key       (in_data.item_value),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_vals[i]),
      .flag      (cell_flags[i])
    );
  end

  for (genvar i = CAPACITY; i < NC; i++) begin : g_pad
    assign cell_vals[i]  = '0;
    assign cell_flags[i] = 1'b0;
  end

  ole_scan #(
    .NG  (NG),
    .NGW (NGW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .first_grp (scan_first),
    .last_grp  (scan_last),
    .flags     (cell_flags),
    .vals      (cell_vals),
    .stat      (scan_stat),
    .idx       (scan_idx),
    .value     (scan_val)
  );

`ifndef ASSERT_OFF
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("State register is not one-hot.");

  a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> state_r == S_SCAN)
    else $error("Scan finished outside the scan state.");

  a_pos_hit: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done && (req_is_del || req_r == ole_pkg::REQ_READ_AT) |-> scan_stat.found)
    else $error("Positional scan missed its target cell.");

  a_len_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> len_r == $past(len_r))
    else $error("Entry count changed during a scan.");
`endif

endmodule
